@@ src/mlfq_pkg.sv @@
// ============================================================================
// mlfq_pkg
// Shared types, constants and helpers of the feedback-queue thread scheduler.
// ============================================================================
package mlfq_pkg;

    localparam int THREAD_SLOTS = 16;
    localparam int IDX_W        = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;

    localparam int UNIT_W  = 20;
    localparam int THR_W   = 23;
    localparam int WAIT_W  = 24;
    localparam int STAMP_W = 16;
    localparam int SLICE_W = 22;
    localparam int VAL_W   = 32;

    localparam logic [1:0] OP_CREATE = 2'd0;
    localparam logic [1:0] OP_SLICE  = 2'd1;
    localparam logic [1:0] OP_EXIT   = 2'd2;
    localparam logic [1:0] OP_JOIN   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BUSY  = 2'd1;
    localparam logic [1:0] ST_NORUN = 2'd2;

    localparam logic [1:0] LVL_TOP = 2'd3;
    localparam logic [1:0] LVL_LOW = 2'd1;

    localparam int CFG_SLICE_UNIT = 0;
    localparam int CFG_AGE_THR    = 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_EVAL
    } t_state;

    typedef enum logic [2:0] {
        CO_NONE,
        CO_CREATE,
        CO_EXIT,
        CO_DEMOTE,
        CO_AGE
    } t_cell_op;

    // Command broadcast to the row; only the addressed cell acts on its op, while clear_marks reaches every cell.
    typedef struct packed {
        logic                clear_marks;
        t_cell_op            op;
        logic [IDX_W-1:0]    idx;
        logic [1:0]          level;
        logic [WAIT_W-1:0]   wait_time;
        logic                set_stamp;
        logic [STAMP_W-1:0]  stamp;
        logic [VAL_W-1:0]    exit_value;
    } t_cell_cmd;

    // Best candidate found so far, handed from cell to cell.
    typedef struct packed {
        logic                valid;
        logic [IDX_W-1:0]    idx;
        logic [STAMP_W-1:0]  age;
        logic [1:0]          level;
        logic [WAIT_W-1:0]   wait_time;
    } t_token;

    typedef struct packed {
        logic                used;
        logic                done;
        logic [1:0]          level;
        logic [VAL_W-1:0]    exit_value;
    } t_cell_stat;

    // unit * (4 - level), kept to the slice width.
    function automatic logic [SLICE_W-1:0] slice_mul(input logic [UNIT_W-1:0] unit,
                                                     input logic [1:0] lvl);
        logic [SLICE_W-1:0] u;
        u = SLICE_W'(unit);
        unique case (lvl)
            2'd1:    slice_mul = (u << 1) + u;
            2'd2:    slice_mul = u << 1;
            2'd3:    slice_mul = u;
            default: slice_mul = u << 2;
        endcase
    endfunction

endpackage

@@ src/mlfq_cell.sv @@
// ============================================================================
// mlfq_cell
// One thread slot: holds its state and passes the best candidate onward.
// ============================================================================
module mlfq_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [mlfq_pkg::IDX_W-1:0]    i_idx,
    input  mlfq_pkg::t_cell_cmd           i_cmd,
    input  logic [mlfq_pkg::STAMP_W-1:0]  i_stamp_now,
    input  logic                          i_use_marks,
    input  mlfq_pkg::t_token              i_tok,
    output mlfq_pkg::t_token              o_tok,
    output mlfq_pkg::t_cell_stat          o_stat
);
    import mlfq_pkg::*;

    logic                r_used, r_done, r_mark;
    logic [1:0]          r_level;
    logic [WAIT_W-1:0]   r_wait;
    logic [STAMP_W-1:0]  r_stamp;
    logic [VAL_W-1:0]    r_exit;
    t_token              r_tok;
    t_token              n_tok;

    logic                w_hit;
    logic [STAMP_W-1:0]  w_age;
    logic                w_cand;
    logic                w_better;

    assign w_hit  = (i_cmd.op != CO_NONE) && (i_cmd.idx == i_idx);
    assign w_age  = i_stamp_now - r_stamp;
    assign w_cand = r_used && !r_done && !(i_use_marks && r_mark);

    // Higher level wins, then the older stamp; ties keep the lower slot.
    always_comb begin
        w_better = w_cand && (!i_tok.valid || (r_level > i_tok.level) ||
                   ((r_level == i_tok.level) && (w_age > i_tok.age)));
        n_tok = i_tok;
        if (w_better) begin
            n_tok.valid     = 1'b1;
            n_tok.idx       = i_idx;
            n_tok.age       = w_age;
            n_tok.level     = r_level;
            n_tok.wait_time = r_wait;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= 1'b0;
            r_done  <= 1'b0;
            r_mark  <= 1'b0;
            r_level <= '0;
            r_wait  <= '0;
            r_tok   <= '0;
        end else begin
            r_tok <= n_tok;
            if (i_cmd.clear_marks) begin
                r_mark <= 1'b0;
            end
            if (w_hit) begin
                unique case (i_cmd.op)
                    CO_CREATE: begin
                        r_used  <= 1'b1;
                        r_done  <= 1'b0;
                        r_level <= LVL_TOP;
                        r_wait  <= '0;
                    end
                    CO_EXIT: begin
                        r_done <= 1'b1;
                    end
                    CO_DEMOTE: begin
                        r_level <= i_cmd.level;
                    end
                    CO_AGE: begin
                        r_mark  <= 1'b1;
                        r_level <= i_cmd.level;
                        r_wait  <= i_cmd.wait_time;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hit && ((i_cmd.op == CO_CREATE) || (i_cmd.op == CO_DEMOTE) ||
                      ((i_cmd.op == CO_AGE) && i_cmd.set_stamp))) begin
            r_stamp <= i_cmd.stamp;
        end
        if (w_hit && (i_cmd.op == CO_EXIT)) begin
            r_exit <= i_cmd.exit_value;
        end
    end

    assign o_tok             = r_tok;
    assign o_stat.used       = r_used;
    assign o_stat.done       = r_done;
    assign o_stat.level      = r_level;
    assign o_stat.exit_value = r_exit;

endmodule

@@ src/mlfq_thread_scheduler.sv @@
// ============================================================================
// mlfq_thread_scheduler
// Three-level feedback-queue scheduler built as a row of thread-slot cells.
// ============================================================================
// Create, join and exit with no running thread: result in the cycle after the transfer.
// Slice end and exit: K + 2 sweeps of the cell row, K waiting threads (one sweep
// per aged thread, one that finds none left, one for the pick). One item is in
// flight; the next transfer waits until the result has been taken. Synchronous
// active-low reset clears all slots, the running thread and the stamp counter
// and loads the default configuration.
module mlfq_thread_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // thread_id[3:0], exit_value[35:4]
    input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // run_thread[3:0], slice_length[25:4],
                                       // join_value[57:26], status[59:58]
    output logic [1:0]  m_axis_tuser,  // run_valid[0], join_done[1]
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [22:0] i_cfg_data
);
    import mlfq_pkg::*;

    // Input fields.
    logic [1:0]        w_op;
    logic [3:0]        w_tid;
    logic [VAL_W-1:0]  w_xval;
    logic [IDX_W-1:0]  w_tid_idx;
    logic              w_tid_ok;
    logic              w_in_acc;

    assign w_op      = s_axis_tuser;
    assign w_tid     = s_axis_tdata[3:0];
    assign w_xval    = s_axis_tdata[35:4];
    assign w_tid_idx = IDX_W'(w_tid);
    assign w_tid_ok  = (32'(w_tid) < THREAD_SLOTS);

    // Controller state.
    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_cnt, n_cnt;
    logic                r_use_marks, n_use_marks;
    logic [SLICE_W-1:0]  r_gain, n_gain;
    logic [STAMP_W-1:0]  r_stamp, n_stamp;
    logic                r_run_valid, n_run_valid;
    logic [IDX_W-1:0]    r_run_slot, n_run_slot;
    logic [UNIT_W-1:0]   r_slice_unit;
    logic [THR_W-1:0]    r_age_thr;

    // Result register.
    logic                r_out_valid, n_out_valid;
    logic                r_o_rv, n_o_rv;
    logic [3:0]          r_o_rt, n_o_rt;
    logic [SLICE_W-1:0]  r_o_sl, n_o_sl;
    logic                r_o_jd, n_o_jd;
    logic [VAL_W-1:0]    r_o_jv, n_o_jv;
    logic [1:0]          r_o_st, n_o_st;

    // Cell row.
    t_cell_cmd   w_cmd;
    t_token      w_tok [THREAD_SLOTS+1];
    t_cell_stat  w_stat [THREAD_SLOTS];
    t_token      w_best;

    assign w_tok[0] = '0;
    assign w_best   = w_tok[THREAD_SLOTS];

    for (genvar g = 0; g < THREAD_SLOTS; g++) begin : g_cell
        mlfq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_idx       (IDX_W'(g)),
            .i_cmd       (w_cmd),
            .i_stamp_now (r_stamp),
            .i_use_marks (r_use_marks),
            .i_tok       (w_tok[g]),
            .o_tok       (w_tok[g+1]),
            .o_stat      (w_stat[g])
        );
    end

    // The block takes a new item only when idle with the result slot free.
    assign s_axis_tready = (r_state == S_IDLE) && !r_out_valid;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // Running thread's level, folded to the top level if no thread runs or the level were ever invalid.
    logic [1:0]          w_run_lvl;
    logic [1:0]          w_p;
    logic [1:0]          w_demoted;
    logic [WAIT_W:0]     w_sum;
    logic [WAIT_W-1:0]   w_sat;
    logic                w_promo;

    assign w_run_lvl = w_stat[r_run_slot].level;
    assign w_p       = (r_run_valid && (w_run_lvl != 2'd0)) ? w_run_lvl : LVL_TOP;
    assign w_demoted = (w_p > LVL_LOW) ? (w_p - 2'd1) : LVL_LOW;

    // Aging arithmetic for the candidate that the sweep delivered.
    assign w_sum   = {1'b0, w_best.wait_time} + (WAIT_W+1)'(r_gain);
    assign w_sat   = w_sum[WAIT_W] ? {WAIT_W{1'b1}} : w_sum[WAIT_W-1:0];
    assign w_promo = (w_best.level < LVL_TOP) && (w_sat > WAIT_W'(r_age_thr));

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && ((w_op == OP_SLICE) ||
                                 ((w_op == OP_EXIT) && r_run_valid))) begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (r_cnt == IDX_W'(THREAD_SLOTS - 1)) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = r_use_marks ? S_SWEEP : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and command logic.
    always_comb begin
        n_cnt       = r_cnt;
        n_use_marks = r_use_marks;
        n_gain      = r_gain;
        n_stamp     = r_stamp;
        n_run_valid = r_run_valid;
        n_run_slot  = r_run_slot;
        n_out_valid = r_out_valid;
        n_o_rv      = r_o_rv;
        n_o_rt      = r_o_rt;
        n_o_sl      = r_o_sl;
        n_o_jd      = r_o_jd;
        n_o_jv      = r_o_jv;
        n_o_st      = r_o_st;
        w_cmd       = '0;
        w_cmd.op    = CO_NONE;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_o_rv = 1'b0;
                    n_o_rt = '0;
                    n_o_sl = '0;
                    n_o_jd = 1'b0;
                    n_o_jv = '0;
                    n_o_st = ST_OK;
                    unique case (w_op)
                        OP_CREATE: begin
                            n_out_valid = 1'b1;
                            if (!w_tid_ok || w_stat[w_tid_idx].used) begin
                                n_o_st = ST_BUSY;
                            end else begin
                                w_cmd.op    = CO_CREATE;
                                w_cmd.idx   = w_tid_idx;
                                w_cmd.stamp = r_stamp;
                                n_stamp     = r_stamp + 1'b1;
                            end
                        end
                        OP_JOIN: begin
                            n_out_valid = 1'b1;
                            if (w_tid_ok && w_stat[w_tid_idx].used &&
                                w_stat[w_tid_idx].done) begin
                                n_o_jd = 1'b1;
                                n_o_jv = w_stat[w_tid_idx].exit_value;
                            end
                        end
                        OP_SLICE, OP_EXIT: begin
                            if ((w_op == OP_EXIT) && !r_run_valid) begin
                                n_out_valid = 1'b1;
                                n_o_st      = ST_NORUN;
                            end else begin
                                n_gain            = slice_mul(r_slice_unit, w_p);
                                w_cmd.clear_marks = 1'b1;
                                n_use_marks       = 1'b1;
                                n_cnt             = '0;
                                n_run_valid       = 1'b0;
                                if (r_run_valid) begin
                                    w_cmd.idx        = r_run_slot;
                                    w_cmd.level      = w_demoted;
                                    w_cmd.stamp      = r_stamp;
                                    w_cmd.exit_value = w_xval;
                                    if (w_op == OP_EXIT) begin
                                        w_cmd.op = CO_EXIT;
                                    end else begin
                                        w_cmd.op = CO_DEMOTE;
                                        n_stamp  = r_stamp + 1'b1;
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                n_cnt = r_cnt + 1'b1;
            end
            S_EVAL: begin
                n_cnt = '0;
                if (r_use_marks) begin
                    if (w_best.valid) begin
                        // Age the best unvisited thread (highest level, then oldest); it may move up a level.
                        w_cmd.op        = CO_AGE;
                        w_cmd.idx       = w_best.idx;
                        w_cmd.level     = w_promo ? (w_best.level + 2'd1) : w_best.level;
                        w_cmd.wait_time = w_promo ? '0 : w_sat;
                        w_cmd.set_stamp = w_promo;
                        w_cmd.stamp     = r_stamp;
                        if (w_promo) begin
                            n_stamp = r_stamp + 1'b1;
                        end
                    end else begin
                        n_use_marks = 1'b0;
                    end
                end else begin
                    n_out_valid = 1'b1;
                    if (w_best.valid) begin
                        n_run_valid = 1'b1;
                        n_run_slot  = w_best.idx;
                        n_o_rv      = 1'b1;
                        n_o_rt      = 4'(w_best.idx);
                        n_o_sl      = slice_mul(r_slice_unit, w_best.level);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_use_marks  <= 1'b0;
            r_stamp      <= '0;
            r_run_valid  <= 1'b0;
            r_run_slot   <= '0;
            r_out_valid  <= 1'b0;
            r_slice_unit <= UNIT_W'(100000);
            r_age_thr    <= THR_W'(600000);
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_use_marks <= n_use_marks;
            r_stamp     <= n_stamp;
            r_run_valid <= n_run_valid;
            r_run_slot  <= n_run_slot;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                if (i_cfg_index == 1'(CFG_SLICE_UNIT)) begin
                    r_slice_unit <= i_cfg_data[UNIT_W-1:0];
                end else begin
                    r_age_thr <= i_cfg_data[THR_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_gain <= n_gain;
        r_o_rv <= n_o_rv;
        r_o_rt <= n_o_rt;
        r_o_sl <= n_o_sl;
        r_o_jd <= n_o_jd;
        r_o_jv <= n_o_jv;
        r_o_st <= n_o_st;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_o_st, r_o_jv, r_o_sl, r_o_rt};
    assign m_axis_tuser  = {r_o_jd, r_o_rv};

    // The running thread is always a live, unfinished slot.
    a_run_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_valid |-> (w_stat[r_run_slot].used && !w_stat[r_run_slot].done))
        else $error("running thread is not a live slot");

    // A successful create takes exactly one stamp.
    a_create_stamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (w_op == OP_CREATE) && w_tid_ok && !w_stat[w_tid_idx].used)
        |=> (r_stamp == $past(r_stamp) + 1'b1))
        else $error("create did not advance the stamp counter");

    // A reported pick is the thread that now runs.
    a_pick_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_valid) && r_o_rv) |-> (r_run_valid && (4'(r_run_slot) == r_o_rt)))
        else $error("reported pick does not match the running thread");

    // No new item while a scheduling pass is under way.
    a_busy_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (!s_axis_tready && !r_out_valid))
        else $error("input taken or result shown during a scheduling pass");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking bench for the three-level feedback-queue thread scheduler.
// ============================================================================
// The bench keeps its own copy of the thread table and the configuration. It
// works out the expected result for every command transfer that the block
// accepts, and it compares each result transfer field by field. Directed
// items come first, then random traffic under several settings, with random
// stalls on both buses, one long output hold-off, and a quiet final phase.
module testbench;
    import mlfq_pkg::*;

    // Expected content of one result transfer.
    typedef struct {
        bit          run_valid;
        logic [3:0]  run_thread;
        logic [21:0] slice_length;
        bit          join_done;
        logic [31:0] join_value;
        logic [1:0]  status;
    } t_sched_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [22:0] i_cfg_data;

    mlfq_thread_scheduler u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Shadow copy of the scheduler state.
    bit          thr_used [16];
    bit          thr_done [16];
    logic [1:0]  thr_level [16];
    logic [23:0] thr_wait [16];
    logic [15:0] thr_stamp [16];
    logic [31:0] thr_exit [16];
    bit          cur_valid;
    logic [3:0]  cur_slot;
    logic [15:0] next_stamp;
    logic [19:0] base_slice;
    logic [22:0] promote_limit;

    t_sched_result pending_results[$];

    int  errors = 0;
    int  cmd_count = 0;
    int  result_count = 0;
    int  dispatch_count = 0;
    int  join_hits = 0;
    int  promotions = 0;
    bit  send_gaps = 1;       // random idle bursts on the command side
    bit  recv_gaps = 1;       // random stall bursts on the result side
    int  hold_request = 0;    // one-shot long hold-off of the result side

    // ------------------------------------------------------------------
    // Clock, reset and run limit.
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 3_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor of the scheduler.
    // ------------------------------------------------------------------
    function automatic logic [15:0] stamp_age(int i);
        return next_stamp - thr_stamp[i];
    endfunction

    function automatic void take_stamp(int i);
        thr_stamp[i] = next_stamp;
        next_stamp   = next_stamp + 16'd1;
    endfunction

    // Oldest waiting thread at a level, skipping marked ones; 16 if none.
    // Ties keep the lowest slot since only a strictly larger age wins.
    function automatic int oldest_thread(logic [1:0] lvl, bit use_marks, bit marks[16]);
        int best;
        logic [15:0] best_age;
        best = 16;
        best_age = '0;
        for (int i = 0; i < 16; i++) begin
            if (thr_used[i] && !thr_done[i] && thr_level[i] == lvl &&
                !(use_marks && marks[i])) begin
                if (best == 16 || stamp_age(i) > best_age) begin
                    best = i;
                    best_age = stamp_age(i);
                end
            end
        end
        return best;
    endfunction

    // Every waiting thread gains wait time, highest level and oldest first,
    // because a promotion hands out a fresh stamp and so reorders the rest.
    function automatic void age_waiting(int gain);
        bit marks[16];
        int i;
        longint sum;
        for (int k = 0; k < 16; k++) marks[k] = 0;
        for (int lvl = 3; lvl >= 1; lvl--) begin
            forever begin
                i = oldest_thread(lvl[1:0], 1, marks);
                if (i == 16) break;
                marks[i] = 1;
                sum = longint'(thr_wait[i]) + gain;
                thr_wait[i] = (sum > 24'hFFFFFF) ? 24'hFFFFFF : sum[23:0];
                if (lvl < 3 && thr_wait[i] > promote_limit) begin
                    thr_level[i] = lvl[1:0] + 2'd1;
                    thr_wait[i] = '0;
                    take_stamp(i);
                    promotions++;
                end
            end
        end
    endfunction

    function automatic t_sched_result schedule_step(logic [1:0] op, logic [3:0] tid,
                                                    logic [31:0] xval);
        t_sched_result r;
        int p;
        int pick;
        bit none[16];
        r = '{0, '0, '0, 0, '0, ST_OK};
        p = 3;
        pick = 16;
        if (op == OP_CREATE) begin
            if (thr_used[tid]) begin
                r.status = ST_BUSY;
            end else begin
                thr_used[tid]  = 1;
                thr_level[tid] = LVL_TOP;
                thr_wait[tid]  = '0;
                thr_done[tid]  = 0;
                take_stamp(tid);
            end
        end else if (op == OP_JOIN) begin
            if (thr_used[tid] && thr_done[tid]) begin
                r.join_done  = 1;
                r.join_value = thr_exit[tid];
            end
        end else if (op == OP_EXIT && !cur_valid) begin
            r.status = ST_NORUN;
        end else begin
            if (cur_valid) begin
                p = thr_level[cur_slot];
                if (p < 1) p = 3;
                if (op == OP_EXIT) begin
                    thr_done[cur_slot] = 1;
                    thr_exit[cur_slot] = xval;
                end else begin
                    thr_level[cur_slot] = (p > 1) ? 2'(p - 1) : LVL_LOW;
                    take_stamp(cur_slot);
                end
                cur_valid = 0;
            end
            age_waiting(int'(base_slice) * (4 - p));
            for (int lvl = 3; lvl >= 1 && pick == 16; lvl--)
                pick = oldest_thread(lvl[1:0], 0, none);
            if (pick != 16) begin
                cur_valid = 1;
                cur_slot = pick[3:0];
                r.run_valid = 1;
                r.run_thread = pick[3:0];
                r.slice_length = 22'(int'(base_slice) * (4 - int'(thr_level[pick])));
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Command side.
    // ------------------------------------------------------------------
    // Offers one command and holds it until it is taken. Valid is left high
    // when no gap follows so that the next command goes out back to back.
    task automatic send_command(logic [1:0] op, logic [3:0] tid, logic [31:0] xval);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, xval, tid};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(schedule_step(op, tid, xval));
        cmd_count++;
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    // Waits for every result, then idles before reprogramming.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_register(bit idx, logic [22:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_SLICE_UNIT) base_slice = value[19:0];
        else promote_limit = value;
        @(posedge i_clk);
    endtask

    // Random traffic: mostly slice ends so that threads move between levels.
    task automatic send_random(int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 12)      send_command(OP_CREATE, 4'($urandom), $urandom);
            else if (pick < 70) send_command(OP_SLICE, 4'($urandom), $urandom);
            else if (pick < 78) send_command(OP_EXIT, 4'($urandom), $urandom);
            else                send_command(OP_JOIN, 4'($urandom), $urandom);
        end
    endtask

    // ------------------------------------------------------------------
    // Test tasks.
    // ------------------------------------------------------------------
    // Empty table cases, a duplicate create, join before and after exit,
    // and data extremes.
    task automatic test_directed();
        send_command(OP_JOIN, 4'd0, 32'h0);
        send_command(OP_EXIT, 4'd0, 32'hFFFF_FFFF);
        send_command(OP_SLICE, 4'd0, 32'h0);
        send_command(OP_CREATE, 4'd0, 32'h0);
        send_command(OP_CREATE, 4'd0, 32'hFFFF_FFFF);
        send_command(OP_CREATE, 4'd15, 32'h0);
        send_command(OP_SLICE, 4'd15, 32'h0);
        send_command(OP_SLICE, 4'd0, 32'h0);
        send_command(OP_SLICE, 4'd0, 32'h0);
        send_command(OP_JOIN, 4'd15, 32'h0);
        send_command(OP_EXIT, 4'd9, 32'hFFFF_FFFF);
        send_command(OP_JOIN, 4'd15, 32'h0);
        send_command(OP_JOIN, 4'd0, 32'h0);
        send_command(OP_CREATE, 4'd15, 32'h0);
        send_command(OP_SLICE, 4'd0, 32'h0);
        send_command(OP_EXIT, 4'd6, 32'h0);
        send_command(OP_JOIN, 4'd0, 32'h0);
        send_command(OP_JOIN, 4'd15, 32'h0);
        send_command(OP_SLICE, 4'd0, 32'h0);
        send_command(OP_EXIT, 4'd0, 32'h0);
    endtask

    // Fill the rest of the table and run at the reset settings.
    task automatic test_default_settings();
        for (int i = 1; i < 15; i++) send_command(OP_CREATE, i[3:0], $urandom);
        send_random(120);
    endtask

    // Tiny slices and a zero threshold promote on every event. The result
    // side is held for a long stretch so the command side backs up.
    task automatic test_fast_promotion();
        wait_idle();
        write_register(1'(CFG_SLICE_UNIT), 23'd1);
        write_register(1'(CFG_AGE_THR), 23'd0);
        hold_request = 400;
        send_random(130);
    endtask

    // Largest slices with the largest threshold; level 3 waiters saturate.
    task automatic test_largest_settings();
        wait_idle();
        write_register(1'(CFG_SLICE_UNIT), 23'hFFFFF);
        write_register(1'(CFG_AGE_THR), 23'h7FFFFF);
        send_random(130);
    endtask

    // Random settings, with no idling on either side at the end.
    task automatic test_random_settings();
        wait_idle();
        write_register(1'(CFG_SLICE_UNIT), 23'($urandom_range(1, 20'hFFFFF)));
        write_register(1'(CFG_AGE_THR), 23'($urandom_range(0, 23'h7FFFFF)));
        send_random(50);
        send_gaps = 0;
        recv_gaps = 0;
        send_random(50);
    endtask

    // ------------------------------------------------------------------
    // Result side: stall bursts, the one long hold-off, and the checker.
    // ------------------------------------------------------------------
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold_request) @(posedge i_clk);
                hold_request = 0;
            end else if (recv_gaps && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_sched_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no command outstanding");
                errors++;
            end else begin
                want = pending_results.pop_front();
                result_count++;
                if (want.run_valid) dispatch_count++;
                if (want.join_done) join_hits++;
                if (m_axis_tuser[0] !== want.run_valid) begin
                    $error("run_valid: expected %0d, got %0d", want.run_valid,
                           m_axis_tuser[0]);
                    errors++;
                end
                if (m_axis_tdata[3:0] !== want.run_thread) begin
                    $error("run_thread: expected %0d, got %0d", want.run_thread,
                           m_axis_tdata[3:0]);
                    errors++;
                end
                if (m_axis_tdata[25:4] !== want.slice_length) begin
                    $error("slice_length: expected %0d, got %0d", want.slice_length,
                           m_axis_tdata[25:4]);
                    errors++;
                end
                if (m_axis_tuser[1] !== want.join_done) begin
                    $error("join_done: expected %0d, got %0d", want.join_done,
                           m_axis_tuser[1]);
                    errors++;
                end
                if (m_axis_tdata[57:26] !== want.join_value) begin
                    $error("join_value: expected %h, got %h", want.join_value,
                           m_axis_tdata[57:26]);
                    errors++;
                end
                if (m_axis_tdata[59:58] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status,
                           m_axis_tdata[59:58]);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        int guard;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = 1'b0;
        i_cfg_data    = '0;
        for (int i = 0; i < 16; i++) begin
            thr_used[i] = 0;
            thr_done[i] = 0;
            thr_level[i] = '0;
            thr_wait[i] = '0;
            thr_stamp[i] = '0;
            thr_exit[i] = '0;
        end
        cur_valid = 0;
        cur_slot = '0;
        next_stamp = '0;
        base_slice = 20'd100000;
        promote_limit = 23'd600000;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_default_settings();
        test_fast_promotion();
        test_largest_settings();
        test_random_settings();

        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 200_000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (50) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            errors++;
        end

        $display("Sent %0d commands and checked %0d results: %0d dispatches,",
                 cmd_count, result_count, dispatch_count);
        $display("%0d joins of exited threads, %0d promotions, over four settings.",
                 join_hits, promotions);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/mlfq_pkg.sv
src/mlfq_cell.sv
src/mlfq_thread_scheduler.sv
test/testbench.sv
